@@ hdl/rrc_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rrc_pkg
// Shared types and constants for the rectangle raster canvas.
// ----------------------------------------------------------------------------
package rrc_pkg;

  localparam int MAX_WIDTH_DEF  = 256;
  localparam int MAX_HEIGHT_DEF = 256;
  localparam int FRAC_BITS_DEF  = 8;

  localparam int COORD_W = 24;   // fixed-point corner and size fields
  localparam int SIZE_W  = 9;    // canvas size registers
  localparam int CHAR_W  = 8;    // character values
  localparam int IDX_W   = 8;    // read row and column

  localparam logic [SIZE_W-1:0] CANVAS_WIDTH_RST  = 9'd256;
  localparam logic [SIZE_W-1:0] CANVAS_HEIGHT_RST = 9'd256;
  localparam logic [CHAR_W-1:0] BACKGROUND_RST    = 8'd32;

  typedef enum logic [1:0] {
    REG_CANVAS_WIDTH  = 2'd0,
    REG_CANVAS_HEIGHT = 2'd1,
    REG_BACKGROUND    = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    OP_DRAW  = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_BAD_SIZE = 2'd1,
    ST_IGNORED  = 2'd2,
    ST_OUTSIDE  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_DECODE,
    S_DRAW,
    S_CLEAR,
    S_RESP
  } state_t;

  typedef struct packed {
    logic    load;
    logic    init_step;
    logic    draw_step;
    logic    out_load;
    status_t out_status;
    logic    out_pixel;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       size_bad;
    logic       outside;
    logic       clr_last;
    logic       draw_last;
  } dp_sts_t;

endpackage
`default_nettype wire

@@ hdl/rrc_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rrc_ctrl
// Request sequencer: decodes requests, owns the corrupted flag and the
// result handshake.
// ----------------------------------------------------------------------------
module rrc_ctrl
  import rrc_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    s_tvalid,
  output logic         s_tready,
  output logic         m_tvalid,
  input  wire logic    m_tready,
  input  wire dp_sts_t sts,
  output dp_cmd_t      cmd
);

  state_t  state, state_next;
  logic    corrupted, corrupted_next;
  status_t resp_st, resp_st_next;
  logic    resp_pix, resp_pix_next;
  logic    out_valid, out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      corrupted <= 1'b0;
      out_valid <= 1'b0;
      resp_st   <= ST_DONE;
      resp_pix  <= 1'b0;
    end else begin
      state     <= state_next;
      corrupted <= corrupted_next;
      out_valid <= out_valid_next;
      resp_st   <= resp_st_next;
      resp_pix  <= resp_pix_next;
    end
  end

  always_comb begin
    state_next     = state;
    corrupted_next = corrupted;
    resp_st_next   = resp_st;
    resp_pix_next  = resp_pix;
    s_tready       = 1'b0;
    cmd            = '0;
    cmd.out_status = resp_st;
    cmd.out_pixel  = resp_pix;
    unique case (state)
      S_INIT: begin
        cmd.init_step = 1'b1;
        if (sts.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        resp_st_next  = ST_DONE;
        resp_pix_next = 1'b0;
        state_next    = S_RESP;
        case (sts.op)
          OP_DRAW: begin
            if (corrupted) begin
              resp_st_next = ST_IGNORED;
            end else if (sts.size_bad) begin
              resp_st_next   = ST_BAD_SIZE;
              corrupted_next = 1'b1;
            end else begin
              state_next = S_DRAW;
            end
          end
          OP_READ: begin
            // read data lands at the end of this cycle
            if (sts.outside) begin
              resp_st_next = ST_OUTSIDE;
            end else begin
              resp_pix_next = 1'b1;
            end
          end
          OP_CLEAR: begin
            state_next = S_CLEAR;
          end
          default: begin
          end
        endcase
      end
      S_DRAW: begin
        cmd.draw_step = 1'b1;
        if (sts.draw_last) begin
          state_next = S_RESP;
        end
      end
      S_CLEAR: begin
        cmd.init_step = 1'b1;
        if (sts.clr_last) begin
          corrupted_next = 1'b0;
          state_next     = S_RESP;
        end
      end
      S_RESP: begin
        // hold until the output register frees up
        if (!out_valid || m_tready) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_next = 1'b1;
    end else if (m_tready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  assign m_tvalid = out_valid;

endmodule
`default_nettype wire

@@ hdl/rrc_dp.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rrc_dp
// Canvas memory, configuration registers, sweep counters, rectangle
// coverage test and result register.
// ----------------------------------------------------------------------------
module rrc_dp
  import rrc_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_valid,
  input  wire logic [1:0]                cfg_index,
  input  wire logic [SIZE_W-1:0]         cfg_data,
  input  wire logic [1:0]                in_cmd,
  input  wire logic                      in_filled,
  input  wire logic signed [COORD_W-1:0] in_left,
  input  wire logic signed [COORD_W-1:0] in_top,
  input  wire logic signed [COORD_W-1:0] in_rect_width,
  input  wire logic signed [COORD_W-1:0] in_rect_height,
  input  wire logic [CHAR_W-1:0]         in_color,
  input  wire logic [IDX_W-1:0]          in_row,
  input  wire logic [IDX_W-1:0]          in_col,
  input  wire dp_cmd_t                   cmd,
  output dp_sts_t                        sts,
  output logic [1:0]                     out_status,
  output logic [CHAR_W-1:0]              out_pixel
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int XW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int YW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int CXW   = $clog2(MAX_WIDTH + 1);
  localparam int CYW   = $clog2(MAX_HEIGHT + 1);
  localparam int CBITS = ((CXW > CYW) ? CXW : CYW) + FRAC_BITS + 1;
  localparam int DW    = ((CBITS > COORD_W + 1) ? CBITS : COORD_W + 1) + 1;

  logic [SIZE_W-1:0] canvas_width, canvas_height;
  logic [CHAR_W-1:0] background;
  logic [CXW-1:0]    cw;
  logic [CYW-1:0]    ch;
  logic [XW-1:0]     cw_m1;
  logic [YW-1:0]     ch_m1;

  logic [AW-1:0]     clr_addr;
  logic              init_busy;
  logic [XW-1:0]     c;
  logic [YW-1:0]     r;

  logic [1:0]               op_q;
  logic                     filled_q;
  logic                     size_bad_q;
  logic signed [DW-1:0]     x1, y1, x2, y2;
  logic [CHAR_W-1:0]        color_q;
  logic [IDX_W-1:0]         row_q, col_q;

  logic signed [DW-1:0]     cx, ry, one;
  logic                     col_in, row_in, col_edge, row_edge, hit;

  logic [CHAR_W-1:0]        mem [DEPTH];
  logic [CHAR_W-1:0]        rdata;
  logic [AW-1:0]            rd_addr, draw_addr, waddr;
  logic [CHAR_W-1:0]        wdata;
  logic                     we;

  // clamp the size registers to the supported range
  always_comb begin
    if (canvas_width == '0) begin
      cw = CXW'(1);
    end else if (32'(canvas_width) > MAX_WIDTH) begin
      cw = CXW'(MAX_WIDTH);
    end else begin
      cw = CXW'(canvas_width);
    end
    if (canvas_height == '0) begin
      ch = CYW'(1);
    end else if (32'(canvas_height) > MAX_HEIGHT) begin
      ch = CYW'(MAX_HEIGHT);
    end else begin
      ch = CYW'(canvas_height);
    end
  end

  assign cw_m1 = XW'(cw - 1'b1);
  assign ch_m1 = YW'(ch - 1'b1);

  always_ff @(posedge clk) begin
    if (rst) begin
      canvas_width  <= CANVAS_WIDTH_RST;
      canvas_height <= CANVAS_HEIGHT_RST;
      background    <= BACKGROUND_RST;
      clr_addr      <= '0;
      init_busy     <= 1'b1;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_CANVAS_WIDTH:  canvas_width  <= cfg_data;
          REG_CANVAS_HEIGHT: canvas_height <= cfg_data;
          REG_BACKGROUND:    background    <= cfg_data[CHAR_W-1:0];
          default: begin
          end
        endcase
      end
      if (cmd.load) begin
        clr_addr <= '0;
      end else if (cmd.init_step) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (cmd.init_step && sts.clr_last) begin
        init_busy <= 1'b0;
      end
    end
  end

  // capture the request and precompute the far edges
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q       <= in_cmd;
      filled_q   <= in_filled;
      size_bad_q <= in_rect_width[COORD_W-1] || (in_rect_width == '0) ||
                    in_rect_height[COORD_W-1] || (in_rect_height == '0);
      x1         <= DW'(in_left);
      y1         <= DW'(in_top);
      x2         <= DW'(in_left) + DW'(in_rect_width);
      y2         <= DW'(in_top) + DW'(in_rect_height);
      color_q    <= in_color;
      row_q      <= in_row;
      col_q      <= in_col;
      c          <= '0;
      r          <= '0;
    end else if (cmd.draw_step) begin
      if (c == cw_m1) begin
        c <= '0;
        r <= r + 1'b1;
      end else begin
        c <= c + 1'b1;
      end
    end
  end

  assign one = $signed(DW'(1) << FRAC_BITS);
  assign cx  = $signed(DW'(c) << FRAC_BITS);
  assign ry  = $signed(DW'(r) << FRAC_BITS);

  assign col_in   = (cx >= x1) && (cx <= x2);
  assign row_in   = (ry >= y1) && (ry <= y2);
  assign col_edge = ((cx - x1) < one) || ((x2 - cx) < one);
  assign row_edge = ((ry - y1) < one) || ((y2 - ry) < one);
  assign hit      = col_in && row_in && (filled_q || col_edge || row_edge);

  assign draw_addr = AW'(32'(r) * MAX_WIDTH + 32'(c));
  assign rd_addr   = AW'(32'(row_q) * MAX_WIDTH + 32'(col_q));
  assign we        = cmd.init_step || (cmd.draw_step && hit);
  assign waddr     = cmd.init_step ? clr_addr : draw_addr;
  // power-up fill always uses the reset background
  assign wdata     = cmd.init_step ? (init_busy ? BACKGROUND_RST : background) : color_q;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status <= cmd.out_status;
      out_pixel  <= cmd.out_pixel ? rdata : '0;
    end
  end

  assign sts.op        = op_q;
  assign sts.size_bad  = size_bad_q;
  assign sts.outside   = (32'(row_q) >= 32'(ch)) || (32'(col_q) >= 32'(cw));
  assign sts.clr_last  = (clr_addr == AW'(DEPTH - 1));
  assign sts.draw_last = (c == cw_m1) && (r == ch_m1);

endmodule
`default_nettype wire

@@ hdl/rectangle_raster_canvas_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rectangle_raster_canvas_unit
// Character canvas with rectangle fill/outline draw, pixel read and clear.
// ----------------------------------------------------------------------------
// One request is in flight at a time; its result can wait in the output
// register while the next request is taken. A draw sweeps the in-use area one
// pixel per cycle through the single canvas write port. A clear writes every
// canvas entry the same way. After reset the canvas is filled with the reset
// background value in a pass during which no request is accepted;
// configuration writes are always taken.
module rectangle_raster_canvas_unit
  import rrc_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                s_tvalid,
  output logic                     s_tready,
  // filled[0], left[24:1], top[48:25], rect_width[72:49],
  // rect_height[96:73], color[104:97], row[112:105], col[120:113]
  input  wire logic [127:0]        s_tdata,
  // cmd[1:0]
  input  wire logic [1:0]          s_tuser,
  output logic                     m_tvalid,
  input  wire logic                m_tready,
  // pixel[7:0]
  output logic [7:0]               m_tdata,
  // status[1:0]
  output logic [1:0]               m_tuser,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [1:0]          cfg_index,
  input  wire logic [SIZE_W-1:0]   cfg_data
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  assign cfg_ready = 1'b1;

  rrc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  rrc_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_cmd         (s_tuser),
    .in_filled      (s_tdata[0]),
    .in_left        (s_tdata[24:1]),
    .in_top         (s_tdata[48:25]),
    .in_rect_width  (s_tdata[72:49]),
    .in_rect_height (s_tdata[96:73]),
    .in_color       (s_tdata[104:97]),
    .in_row         (s_tdata[112:105]),
    .in_col         (s_tdata[120:113]),
    .cmd            (cmd),
    .sts            (sts),
    .out_status     (m_tuser),
    .out_pixel      (m_tdata)
  );

endmodule
`default_nettype wire

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for rectangle_raster_canvas_unit. A directed table
// covers reset contents, size clamping, exact fixed-point edges, outline and
// filled draws, the sticky bad-size flag, unused commands and clear. Random
// phases follow under several canvas sizes and handshake idle patterns. Each
// reply is checked against a shadow canvas kept by the bench or a table value.
// ----------------------------------------------------------------------------
module tb;
  import rrc_pkg::*;

  localparam int          LIMIT     = 4_000_000;
  localparam logic [1:0]  OP_UNUSED = 2'd3;
  localparam int          KIND_MIX  = 0;
  localparam int          KIND_READ = 1;
  localparam int          KIND_DRAW = 2;

  typedef struct {
    logic [1:0]                op;
    logic                      filled;
    logic signed [COORD_W-1:0] left;
    logic signed [COORD_W-1:0] top;
    logic signed [COORD_W-1:0] rw;
    logic signed [COORD_W-1:0] rh;
    logic [CHAR_W-1:0]         color;
    logic [IDX_W-1:0]          row;
    logic [IDX_W-1:0]          col;
  } item_t;

  typedef struct {
    status_t           status;
    logic [CHAR_W-1:0] pixel;
  } reply_t;

  typedef struct {
    bit                is_cfg;
    reg_idx_t          ri;
    logic [SIZE_W-1:0] rv;
    item_t             it;
    bit                typed;
    status_t           ts;
    logic [CHAR_W-1:0] tp;
  } step_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [127:0]        s_tdata = '0;
  logic [1:0]          s_tuser = '0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [7:0]          m_tdata;
  logic [1:0]          m_tuser;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [1:0]          cfg_index = '0;
  logic [SIZE_W-1:0]   cfg_data = '0;

  // shadow copy of the block state
  logic [CHAR_W-1:0]   shadow_canvas [MAX_WIDTH_DEF*MAX_HEIGHT_DEF];
  bit                  shadow_corrupt;
  logic [SIZE_W-1:0]   shadow_w;
  logic [SIZE_W-1:0]   shadow_h;
  logic [SIZE_W-1:0]   shadow_bg;

  reply_t              pending_replies [$];
  step_t               steps [$];
  int                  fails = 0;
  int                  snd_idle = 0;
  int                  rcv_idle = 0;
  int                  stall_left = 0;

  rectangle_raster_canvas_unit dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    repeat (LIMIT) @(posedge clk);
    $display("** rectangle_raster_canvas_unit: FAILED **");
    $finish;
  end

  function automatic int in_use(logic [SIZE_W-1:0] v, int maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  task automatic blit_predict(input item_t it, output reply_t rp);
    int     cw;
    int     ch;
    longint x;
    longint y;
    longint x2;
    longint y2;
    longint ry;
    longint cx;
    longint one;
    bit     on_rim;
    cw = in_use(shadow_w, MAX_WIDTH_DEF);
    ch = in_use(shadow_h, MAX_HEIGHT_DEF);
    one = longint'(1) <<< FRAC_BITS_DEF;
    rp.status = ST_DONE;
    rp.pixel = '0;
    case (it.op)
      OP_DRAW: begin
        if (shadow_corrupt) begin
          rp.status = ST_IGNORED;
        end else if (it.rw <= 0 || it.rh <= 0) begin
          shadow_corrupt = 1'b1;
          rp.status = ST_BAD_SIZE;
        end else begin
          x = it.left;
          y = it.top;
          x2 = x + longint'(it.rw);
          y2 = y + longint'(it.rh);
          for (int r = 0; r < ch; r++) begin
            ry = longint'(r) <<< FRAC_BITS_DEF;
            if (ry < y || ry > y2) continue;
            for (int c = 0; c < cw; c++) begin
              cx = longint'(c) <<< FRAC_BITS_DEF;
              if (cx < x || cx > x2) continue;
              on_rim = (ry - y < one) || (y2 - ry < one) || (cx - x < one) || (x2 - cx < one);
              if (it.filled || on_rim) shadow_canvas[r*MAX_WIDTH_DEF + c] = it.color;
            end
          end
        end
      end
      OP_READ: begin
        if (it.row >= ch || it.col >= cw) rp.status = ST_OUTSIDE;
        else rp.pixel = shadow_canvas[it.row*MAX_WIDTH_DEF + it.col];
      end
      OP_CLEAR: begin
        foreach (shadow_canvas[i]) shadow_canvas[i] = shadow_bg[CHAR_W-1:0];
        shadow_corrupt = 1'b0;
      end
      default: ;
    endcase
  endtask

  function automatic void add_cfg(reg_idx_t ri, logic [SIZE_W-1:0] v);
    step_t s;
    s.is_cfg = 1'b1;
    s.ri = ri;
    s.rv = v;
    s.typed = 1'b0;
    steps.push_back(s);
  endfunction

  function automatic void add_op(logic [1:0] op, logic filled, logic [23:0] left,
                                 logic [23:0] top, logic [23:0] rw, logic [23:0] rh,
                                 logic [7:0] color, logic [7:0] row, logic [7:0] col,
                                 bit typed, status_t ts, logic [7:0] tp);
    step_t s;
    s.is_cfg = 1'b0;
    s.ri = REG_CANVAS_WIDTH;
    s.rv = '0;
    s.it.op = op;
    s.it.filled = filled;
    s.it.left = left;
    s.it.top = top;
    s.it.rw = rw;
    s.it.rh = rh;
    s.it.color = color;
    s.it.row = row;
    s.it.col = col;
    s.typed = typed;
    s.ts = ts;
    s.tp = tp;
    steps.push_back(s);
  endfunction

  // drop the request line and wait for every outstanding reply
  task automatic drain();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t ri, input logic [SIZE_W-1:0] v);
    drain();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= ri;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    case (ri)
      REG_CANVAS_WIDTH:  shadow_w = v;
      REG_CANVAS_HEIGHT: shadow_h = v;
      REG_BACKGROUND:    shadow_bg = v;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_item(input item_t it, input bit typed, input status_t ts,
                           input logic [7:0] tp);
    reply_t rp;
    @(negedge clk);
    while ($urandom_range(99) < snd_idle) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= it.op;
    s_tdata <= {7'b0, it.col, it.row, it.color, it.rh, it.rw, it.top, it.left, it.filled};
    do @(posedge clk); while (!s_tready);
    blit_predict(it, rp);
    if (typed) begin
      rp.status = ts;
      rp.pixel = tp;
    end
    pending_replies.push_back(rp);
  endtask

  task automatic roll_item(input int cw, input int ch, input bit allow_bad, input int kind,
                           output item_t it);
    int k;
    int a;
    int frac;
    it.op = OP_CLEAR;
    it.filled = $urandom_range(1);
    it.left = $urandom();
    it.top = $urandom();
    it.rw = $urandom();
    it.rh = $urandom();
    it.color = $urandom();
    it.row = $urandom();
    it.col = $urandom();
    k = $urandom_range(99);
    if (kind == KIND_DRAW) k = 0;
    else if (kind == KIND_READ) k = 50;
    if (k < 45) begin
      it.op = OP_DRAW;
      if ($urandom_range(3) != 0) begin
        // keep the rectangle near the in-use area
        frac = $urandom_range(1) ? $urandom_range(255) : 0;
        a = $urandom_range(cw + 3);
        it.left = (a - 2) * 256 + frac;
        frac = $urandom_range(1) ? $urandom_range(255) : 0;
        a = $urandom_range(ch + 3);
        it.top = (a - 2) * 256 + frac;
        it.rw = $urandom_range((cw + 2) * 256, 1);
        it.rh = $urandom_range((ch + 2) * 256, 1);
      end else begin
        it.rw[COORD_W-1] = 1'b0;
        it.rh[COORD_W-1] = 1'b0;
        if (it.rw == 0) it.rw = 1;
        if (it.rh == 0) it.rh = 1;
      end
      if (allow_bad && $urandom_range(2) == 0) begin
        if ($urandom_range(1)) it.rw = $urandom_range(1) ? '0 : {1'b1, it.rw[22:0]};
        else it.rh = $urandom_range(1) ? '0 : {1'b1, it.rh[22:0]};
      end
    end else if (k < 93) begin
      it.op = OP_READ;
      if ($urandom_range(9) < 7) begin
        it.row = $urandom_range(ch - 1);
        it.col = $urandom_range(cw - 1);
      end
    end else begin
      it.op = OP_UNUSED;
    end
  endtask

  initial begin
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        m_tready <= 1'b0;
        stall_left = stall_left - 1;
      end else begin
        m_tready <= ($urandom_range(99) >= rcv_idle);
      end
    end
  end

  always @(posedge clk) begin
    reply_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_replies.size() == 0) begin
        if (fails < 10)
          $display("unexpected reply: status %0d pixel %02h", m_tuser, m_tdata);
        fails++;
      end else begin
        want = pending_replies.pop_front();
        if (m_tuser !== want.status || m_tdata !== want.pixel) begin
          if (fails < 10)
            $display("reply mismatch: expected status %0d pixel %02h, got status %0d pixel %02h",
                     want.status, want.pixel, m_tuser, m_tdata);
          fails++;
        end
      end
    end
  end

  initial begin
    item_t             it;
    int                n;
    int                cw;
    int                ch;
    logic [SIZE_W-1:0] wv;
    logic [SIZE_W-1:0] hv;
    logic [SIZE_W-1:0] bv;

    shadow_w = CANVAS_WIDTH_RST;
    shadow_h = CANVAS_HEIGHT_RST;
    shadow_bg = {1'b0, BACKGROUND_RST};
    shadow_corrupt = 1'b0;
    foreach (shadow_canvas[i]) shadow_canvas[i] = BACKGROUND_RST;

    add_op(OP_READ, 0, 0, 0, 0, 0, 0, 0, 0, 1, ST_DONE, 8'd32);
    add_op(OP_READ, 1, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 8'hFF, 8'd255, 8'd255,
           1, ST_DONE, 8'd32);
    // zero width is used as one, oversize height as the maximum
    add_cfg(REG_CANVAS_WIDTH, 9'd0);
    add_cfg(REG_CANVAS_HEIGHT, 9'd511);
    add_op(OP_READ, 0, 0, 0, 0, 0, 0, 8'd0, 8'd1, 1, ST_OUTSIDE, 8'd0);
    add_op(OP_READ, 0, 0, 0, 0, 0, 0, 8'd255, 8'd0, 1, ST_DONE, 8'd32);
    add_cfg(REG_CANVAS_WIDTH, 9'd256);
    add_cfg(REG_CANVAS_HEIGHT, 9'd8);
    add_op(OP_DRAW, 1, 24'h800000, 24'h800000, 24'h7FFFFF, 24'h7FFFFF, 8'h01, 0, 0,
           0, ST_DONE, 0);
    add_op(OP_DRAW, 1, 24'h000000, 24'h000000, 24'h7FFFFF, 24'h7FFFFF, 8'hFF, 0, 0,
           0, ST_DONE, 0);
    add_op(OP_READ, 0, 0, 0, 0, 0, 0, 8'd7, 8'd255, 0, ST_DONE, 0);
    // outline with fractional corners leaves an unpainted interior
    add_op(OP_DRAW, 0, 24'h000180, 24'h000080, 24'h000500, 24'h000500, 8'h52, 0, 0,
           0, ST_DONE, 0);
    add_op(OP_READ, 0, 0, 0, 0, 0, 0, 8'd1, 8'd3, 0, ST_DONE, 0);
    add_op(OP_READ, 0, 0, 0, 0, 0, 0, 8'd3, 8'd4, 0, ST_DONE, 0);
    add_op(OP_READ, 0, 0, 0, 0, 0, 0, 8'd5, 8'd6, 0, ST_DONE, 0);
    add_op(OP_DRAW, 1, 24'h7FFFFF, 24'h000000, 24'h000100, 24'h000100, 8'h11, 0, 0,
           0, ST_DONE, 0);
    // closed rectangle on exact pixel boundaries
    add_op(OP_DRAW, 1, 24'h000300, 24'h000300, 24'h000100, 24'h000100, 8'h72, 0, 0,
           0, ST_DONE, 0);
    add_op(OP_READ, 0, 0, 0, 0, 0, 0, 8'd4, 8'd4, 0, ST_DONE, 0);
    add_op(OP_READ, 0, 0, 0, 0, 0, 0, 8'd5, 8'd5, 0, ST_DONE, 0);
    // shrink and regrow: contents must survive
    add_cfg(REG_CANVAS_WIDTH, 9'd8);
    add_op(OP_READ, 0, 0, 0, 0, 0, 0, 8'd2, 8'd255, 1, ST_OUTSIDE, 8'd0);
    add_cfg(REG_CANVAS_WIDTH, 9'd300);
    add_op(OP_READ, 0, 0, 0, 0, 0, 0, 8'd2, 8'd255, 0, ST_DONE, 0);
    add_op(OP_DRAW, 1, 0, 0, 24'h000000, 24'h000100, 8'h33, 0, 0, 1, ST_BAD_SIZE, 8'd0);
    add_op(OP_DRAW, 1, 0, 0, 24'h000100, 24'h000100, 8'h44, 0, 0, 1, ST_IGNORED, 8'd0);
    add_op(OP_READ, 0, 0, 0, 0, 0, 0, 8'd4, 8'd4, 0, ST_DONE, 0);
    add_op(OP_UNUSED, 1, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 8'hFF, 8'hFF, 8'hFF,
           1, ST_DONE, 8'd0);
    add_cfg(REG_BACKGROUND, 9'h1A5);
    add_op(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 1, ST_DONE, 8'd0);
    add_op(OP_DRAW, 0, 0, 0, 24'h000100, 24'hFFFFFF, 8'h55, 0, 0, 1, ST_BAD_SIZE, 8'd0);
    add_op(OP_READ, 0, 0, 0, 0, 0, 0, 8'd7, 8'd200, 1, ST_DONE, 8'hA5);

    rst = 1'b1;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    snd_idle = 25;
    rcv_idle = 51;
    foreach (steps[i]) begin
      if (steps[i].is_cfg) write_reg(steps[i].ri, steps[i].rv);
      else send_item(steps[i].it, steps[i].typed, steps[i].ts, steps[i].tp);
    end

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin
          snd_idle = 25; rcv_idle = 51;
          wv = $urandom_range(24, 1); hv = $urandom_range(16, 1); bv = 9'h000; n = 30;
        end
        1: begin
          snd_idle = 51; rcv_idle = 25;
          wv = 9'd0; hv = $urandom_range(511, 257); bv = 9'h0FF; n = 25;
        end
        2: begin
          snd_idle = 0; rcv_idle = 0;
          wv = $urandom_range(32, 1); hv = $urandom_range(8, 1); bv = $urandom_range(511);
          n = 30;
        end
        default: begin
          snd_idle = 0; rcv_idle = 0;
          wv = 9'd256; hv = 9'd256; bv = $urandom_range(511); n = 10;
        end
      endcase
      write_reg(REG_CANVAS_WIDTH, wv);
      write_reg(REG_CANVAS_HEIGHT, hv);
      write_reg(REG_BACKGROUND, bv);
      cw = in_use(wv, MAX_WIDTH_DEF);
      ch = in_use(hv, MAX_HEIGHT_DEF);
      if (p != 3) begin
        roll_item(cw, ch, 1'b0, KIND_READ, it);
        it.op = OP_CLEAR;
        send_item(it, 1'b0, ST_DONE, 8'd0);
      end
      for (int i = 0; i < n; i++) begin
        // hold the receiver off so the block backs up into its input
        if (p == 2 && i == 10) stall_left = 300;
        if (p == 2 && i == 20) drain();
        if (p == 3) roll_item(cw, ch, 1'b0, (i == 3 || i == 7) ? KIND_DRAW : KIND_READ, it);
        else roll_item(cw, ch, (p < 2 && i >= n - 4), KIND_MIX, it);
        send_item(it, 1'b0, ST_DONE, 8'd0);
      end
    end

    drain();
    repeat (100) @(posedge clk);
    if (fails == 0 && pending_replies.size() == 0)
      $display("** rectangle_raster_canvas_unit: PASSED **");
    else
      $display("** rectangle_raster_canvas_unit: FAILED **");
    $finish;
  end

endmodule

@@ rectangle_raster_canvas_unit.f @@
hdl/rrc_pkg.sv
hdl/rrc_ctrl.sv
hdl/rrc_dp.sv
hdl/rectangle_raster_canvas_unit.sv
tb/tb.sv
